// File: src/cel_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cel_pkg
// Shared types, codes and default sizes of the lattice event step core.
// ---------------------------------------------------------------------------
package cel_pkg;

	// default sizes for the top-level parameters
	localparam int MAX_SIDE_DEF   = 64;
	localparam int BOND_DEPTH_DEF = 8192;
	localparam int RED_DEPTH_DEF  = 4096;

	// fixed field widths
	localparam int DRAW_W = 31;
	localparam int UNI_W  = 16;
	localparam int RATE_W = 16;
	localparam int SIDE_W = 7;
	localparam int CFG_W  = 16;
	localparam int FRAC_W = 12;

	// register reset values
	localparam logic [SIDE_W-1:0] SIDE_RST   = 7'd64;
	localparam logic [RATE_W-1:0] GROWTH_RST = 16'd4096;
	localparam logic [RATE_W-1:0] CONV_RST   = 16'd1065;

	// register indexes
	localparam logic [1:0] REG_SIDE   = 2'd0;
	localparam logic [1:0] REG_GROWTH = 2'd1;
	localparam logic [1:0] REG_CONV   = 2'd2;

	// commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_EVENT = 1'b1;

	typedef enum logic [1:0] {
		STAT_RUNNING = 2'd0,
		STAT_ESCAPED = 2'd1,
		STAT_EXTINCT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_CHASE  = 2'd0,
		KIND_GROWTH = 2'd1,
		KIND_CONV   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		COL_WHITE = 2'd0,
		COL_BLUE  = 2'd1,
		COL_RED   = 2'd2
	} color_t;

	// list operations
	typedef enum logic [1:0] {
		LOP_PUSH       = 2'd0,
		LOP_DROP_AT    = 2'd1,
		LOP_DROP_MATCH = 2'd2
	} lst_op_t;

	typedef struct packed {
		logic    go;
		logic    clr;
		lst_op_t op;
	} lst_ctl_t;

	typedef struct packed {
		logic              cmd;
		logic [UNI_W-1:0]  uniform_draw;
		logic [DRAW_W-1:0] index_draw;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		kind_t      event_kind;
		logic [5:0] site_row;
		logic [5:0] site_col;
	} out_item_t;

endpackage
`default_nettype wire

// File: src/cel_stream_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cel_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface cel_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/chase_escape_lattice_event_step_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chase_escape_lattice_event_step_core
// Kinetic lattice event engine: blue/red/white sites, chase and growth bond
// lists and a red-site list held in synchronous memories.
// ---------------------------------------------------------------------------
//  channel   dir  payload
//  item      in   cmd, uniform_draw, index_draw
//  result    out  status, event_kind, site_row, site_col
//  cfg_*     in   register write, no read-back
//
//  Start: lattice sweep over all 2**(2*clog2(MAX_SIDE)) sites, then the lists
//  are seeded row by row. Event: each match removal (up to five searches)
//  scans its list entry by entry through the single read port of that list
//  memory, and the remainder of the index draw is taken bit-serially.
//  One item at a time; a new item is taken while a result waits for transfer.
//  Reset clears counts and the escape latch; lists need no clearing.
// ---------------------------------------------------------------------------
module chase_escape_lattice_event_step_core #(
	parameter int MAX_SIDE   = cel_pkg::MAX_SIDE_DEF,
	parameter int BOND_DEPTH = cel_pkg::BOND_DEPTH_DEF,
	parameter int RED_DEPTH  = cel_pkg::RED_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	cel_stream_if.sink                     item,
	cel_stream_if.source                   result,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_addr,
	input  wire logic [cel_pkg::CFG_W-1:0] cfg_data
);
	localparam int CW   = $clog2(MAX_SIDE);
	localparam int LW   = $clog2(MAX_SIDE+1);
	localparam int BAW  = $clog2(BOND_DEPTH);
	localparam int BCW  = $clog2(BOND_DEPTH+1);
	localparam int RAW  = $clog2(RED_DEPTH);
	localparam int RCW  = $clog2(RED_DEPTH+1);
	localparam int NW   = (BCW > RCW) ? BCW : RCW;
	localparam int BW   = 4 * CW;
	localparam int SW   = 2 * CW;
	localparam int WGW  = cel_pkg::RATE_W + BCW;
	localparam int WRW  = cel_pkg::RATE_W + RCW;
	localparam int TW   = ((WGW > WRW) ? WGW : WRW) + 2;
	localparam int PW   = TW + cel_pkg::UNI_W;

	typedef enum logic [4:0] {
		S_IDLE, S_SWEEP, S_INIT, S_INIT_WAIT, S_WGT1, S_WGT2, S_WGT3, S_WGT4,
		S_DIV_WAIT, S_DROP_WAIT, S_PAINT, S_RED_WAIT, S_NB_RD, S_NB_ACT,
		S_NB_WAIT, S_FIN
	} state_t;

	// configuration
	logic [cel_pkg::SIDE_W-1:0] side_cfg_q;
	logic [cel_pkg::RATE_W-1:0] growth_q;
	logic [cel_pkg::RATE_W-1:0] conv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_cfg_q <= cel_pkg::SIDE_RST;
			growth_q   <= cel_pkg::GROWTH_RST;
			conv_q     <= cel_pkg::CONV_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				cel_pkg::REG_SIDE:   side_cfg_q <= cfg_data[cel_pkg::SIDE_W-1:0];
				cel_pkg::REG_GROWTH: growth_q   <= cfg_data[cel_pkg::RATE_W-1:0];
				cel_pkg::REG_CONV:   conv_q     <= cfg_data[cel_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	state_t                     state_q;
	logic [LW-1:0]              side_q;
	logic [LW-1:0]              side_clamp;
	logic                       escaped_q;
	logic [SW-1:0]              sweep_q;
	logic [CW-1:0]              i_q;
	logic [1:0]                 n_q;
	logic [SW-1:0]              site_q;
	cel_pkg::kind_t             kind_q;
	cel_pkg::status_t           stat_q;
	logic [cel_pkg::UNI_W-1:0]  uni_q;
	logic [cel_pkg::DRAW_W-1:0] draw_q;
	logic [TW-1:0]              wb_q, wg_q, wr_q, wbg_q, tot_q;
	logic [PW-1:0]              lhs_q;
	logic                       mod_go_q;
	logic [NW-1:0]              mod_den_q;
	logic                       mod_done;
	logic [NW-1:0]              mod_rem;
	logic                       wait_g_q;
	logic                       out_valid_q;
	cel_pkg::out_item_t         out_data_q;

	cel_pkg::lst_ctl_t          c_ctl_q, g_ctl_q, r_ctl_q;
	logic [BW-1:0]              c_key_q, g_key_q;
	logic [SW-1:0]              r_key_q;
	logic                       c_done, g_done, r_done;
	logic [BW-1:0]              c_entry, g_entry;
	logic [SW-1:0]              r_entry;
	logic [BCW-1:0]             ccnt, gcnt;
	logic [RCW-1:0]             rcnt;

	// clamp the side length taken at start
	always_comb begin
		if (side_cfg_q < cel_pkg::SIDE_W'(2)) begin
			side_clamp = LW'(2);
		end else if (32'(side_cfg_q) > MAX_SIDE) begin
			side_clamp = LW'(MAX_SIDE);
		end else begin
			side_clamp = LW'(side_cfg_q);
		end
	end

	// site coordinates and neighbour of the current step
	logic [CW-1:0] sr, sc, nr, nc;
	logic          nb_ok;
	assign sr = site_q[SW-1:CW];
	assign sc = site_q[CW-1:0];

	always_comb begin
		nr    = sr;
		nc    = sc;
		nb_ok = 1'b1;
		case (n_q)
			2'd0: nr = (sr == '0) ? CW'(side_q - LW'(1)) : sr - CW'(1);
			2'd1: nr = (LW'(sr) + LW'(1) == side_q) ? '0 : sr + CW'(1);
			2'd2: begin
				nc    = sc - CW'(1);
				nb_ok = (sc != '0);
			end
			default: begin
				nc    = sc + CW'(1);
				nb_ok = (LW'(sc) + LW'(1) < side_q);
			end
		endcase
	end

	// bond update for one neighbour
	logic          blue_now;
	logic          nb_go;
	logic          nb_to_g;
	cel_pkg::lst_op_t nb_op;
	logic [BW-1:0] nb_key;
	logic [1:0]    col_rd_q;
	logic [BW-1:0] fwd_key, rev_key;

	assign blue_now = (kind_q != cel_pkg::KIND_GROWTH);
	assign fwd_key  = {sr, sc, nr, nc};
	assign rev_key  = {nr, nc, sr, sc};

	always_comb begin
		nb_go   = 1'b1;
		nb_to_g = 1'b0;
		nb_op   = cel_pkg::LOP_PUSH;
		nb_key  = fwd_key;
		case (col_rd_q)
			cel_pkg::COL_RED: begin
				if (!blue_now) begin
					nb_op   = cel_pkg::LOP_DROP_MATCH;
					nb_to_g = 1'b1;
					nb_key  = rev_key;
				end
			end
			cel_pkg::COL_BLUE: begin
				nb_key = rev_key;
				if (blue_now) begin
					nb_op = cel_pkg::LOP_DROP_MATCH;
				end
			end
			cel_pkg::COL_WHITE: begin
				nb_to_g = 1'b1;
				if (blue_now) begin
					nb_op = cel_pkg::LOP_DROP_MATCH;
				end
			end
			default: nb_go = 1'b0;
		endcase
	end

	// lattice colour memory
	logic [1:0]    color_mem [2**SW];
	logic          col_we;
	logic [SW-1:0] col_waddr;
	logic [1:0]    col_wdata;
	logic          sweep_in;

	assign sweep_in = (LW'(sweep_q[SW-1:CW]) < side_q);

	always_comb begin
		col_we    = 1'b0;
		col_waddr = sweep_q;
		col_wdata = cel_pkg::COL_WHITE;
		case (state_q)
			S_SWEEP: begin
				col_we = 1'b1;
				if (sweep_in && sweep_q[CW-1:0] == '0) begin
					col_wdata = cel_pkg::COL_BLUE;
				end else if (sweep_in && sweep_q[CW-1:0] == CW'(1)) begin
					col_wdata = cel_pkg::COL_RED;
				end
			end
			S_PAINT: begin
				col_we    = 1'b1;
				col_waddr = site_q;
				col_wdata = blue_now ? cel_pkg::COL_BLUE : cel_pkg::COL_RED;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			color_mem[col_waddr] <= col_wdata;
		end
		col_rd_q <= color_mem[{nr, nc}];
	end

	// list and remainder units
	cel_list #(.DEPTH(BOND_DEPTH), .W(BW)) u_chase (
		.clk(clk), .arst_n(arst_n), .ctl(c_ctl_q), .idx(mod_rem[BAW-1:0]),
		.key(c_key_q), .done(c_done), .entry(c_entry), .count(ccnt)
	);

	cel_list #(.DEPTH(BOND_DEPTH), .W(BW)) u_growth (
		.clk(clk), .arst_n(arst_n), .ctl(g_ctl_q), .idx(mod_rem[BAW-1:0]),
		.key(g_key_q), .done(g_done), .entry(g_entry), .count(gcnt)
	);

	cel_list #(.DEPTH(RED_DEPTH), .W(SW)) u_red (
		.clk(clk), .arst_n(arst_n), .ctl(r_ctl_q), .idx(mod_rem[RAW-1:0]),
		.key(r_key_q), .done(r_done), .entry(r_entry), .count(rcnt)
	);

	cel_mod #(.DW(NW)) u_mod (
		.clk(clk), .arst_n(arst_n), .go(mod_go_q), .num(draw_q),
		.den(mod_den_q), .done(mod_done), .rem(mod_rem)
	);

	logic drop_done;
	always_comb begin
		case (kind_q)
			cel_pkg::KIND_CHASE:  drop_done = c_done;
			cel_pkg::KIND_GROWTH: drop_done = g_done;
			default:              drop_done = r_done;
		endcase
	end

	assign item.ready   = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// event sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			side_q      <= LW'(MAX_SIDE);
			escaped_q   <= 1'b0;
			sweep_q     <= '0;
			i_q         <= '0;
			n_q         <= '0;
			site_q      <= '0;
			kind_q      <= cel_pkg::KIND_NONE;
			stat_q      <= cel_pkg::STAT_RUNNING;
			uni_q       <= '0;
			draw_q      <= '0;
			wb_q        <= '0;
			wg_q        <= '0;
			wr_q        <= '0;
			wbg_q       <= '0;
			tot_q       <= '0;
			lhs_q       <= '0;
			mod_go_q    <= 1'b0;
			mod_den_q   <= '0;
			wait_g_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			c_ctl_q     <= '0;
			g_ctl_q     <= '0;
			r_ctl_q     <= '0;
			c_key_q     <= '0;
			g_key_q     <= '0;
			r_key_q     <= '0;
		end else begin
			mod_go_q    <= 1'b0;
			c_ctl_q.go  <= 1'b0;
			c_ctl_q.clr <= 1'b0;
			g_ctl_q.go  <= 1'b0;
			g_ctl_q.clr <= 1'b0;
			r_ctl_q.go  <= 1'b0;
			r_ctl_q.clr <= 1'b0;
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						uni_q  <= item.data.uniform_draw;
						draw_q <= item.data.index_draw;
						site_q <= '0;
						kind_q <= cel_pkg::KIND_NONE;
						stat_q <= cel_pkg::STAT_RUNNING;
						if (item.data.cmd == cel_pkg::CMD_START) begin
							side_q      <= side_clamp;
							escaped_q   <= 1'b0;
							sweep_q     <= '0;
							c_ctl_q.clr <= 1'b1;
							g_ctl_q.clr <= 1'b1;
							r_ctl_q.clr <= 1'b1;
							state_q     <= S_SWEEP;
						end else if (escaped_q) begin
							stat_q  <= cel_pkg::STAT_ESCAPED;
							state_q <= S_FIN;
						end else if (rcnt == '0) begin
							stat_q  <= cel_pkg::STAT_EXTINCT;
							state_q <= S_FIN;
						end else begin
							state_q <= S_WGT1;
						end
					end
				end
				// recolor the whole lattice, one site a cycle
				S_SWEEP: begin
					sweep_q <= sweep_q + SW'(1);
					if (sweep_q == '1) begin
						i_q     <= '0;
						state_q <= S_INIT;
					end
				end
				// seed the lists (growth only for sides above two), one row at a time
				S_INIT: begin
					c_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_PUSH};
					c_key_q <= {i_q, CW'(0), i_q, CW'(1)};
					if (side_q > LW'(2)) begin
						g_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_PUSH};
					end
					g_key_q <= {i_q, CW'(1), i_q, CW'(2)};
					r_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_PUSH};
					r_key_q <= {i_q, CW'(1)};
					state_q <= S_INIT_WAIT;
				end
				S_INIT_WAIT: begin
					if (c_done) begin
						if (LW'(i_q) == side_q - LW'(1)) begin
							state_q <= S_FIN;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_INIT;
						end
					end
				end
				// rate weights
				S_WGT1: begin
					wb_q    <= TW'({ccnt, cel_pkg::FRAC_W'(0)});
					wg_q    <= TW'(growth_q) * TW'(gcnt);
					wr_q    <= TW'(conv_q) * TW'(rcnt);
					state_q <= S_WGT2;
				end
				S_WGT2: begin
					wbg_q   <= wb_q + wg_q;
					tot_q   <= wb_q + wg_q + wr_q;
					state_q <= S_WGT3;
				end
				S_WGT3: begin
					lhs_q   <= PW'(uni_q) * PW'(tot_q);
					state_q <= S_WGT4;
				end
				// pick the event kind and reduce the index draw
				S_WGT4: begin
					mod_go_q <= 1'b1;
					if (lhs_q < {wb_q, cel_pkg::UNI_W'(0)}) begin
						kind_q    <= cel_pkg::KIND_CHASE;
						mod_den_q <= NW'(ccnt);
					end else if (lhs_q < {wbg_q, cel_pkg::UNI_W'(0)}) begin
						kind_q    <= cel_pkg::KIND_GROWTH;
						mod_den_q <= NW'(gcnt);
					end else begin
						kind_q    <= cel_pkg::KIND_CONV;
						mod_den_q <= NW'(rcnt);
					end
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (mod_done) begin
						case (kind_q)
							cel_pkg::KIND_CHASE:
								c_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_DROP_AT};
							cel_pkg::KIND_GROWTH:
								g_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_DROP_AT};
							default:
								r_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_DROP_AT};
						endcase
						state_q <= S_DROP_WAIT;
					end
				end
				S_DROP_WAIT: begin
					if (drop_done) begin
						case (kind_q)
							cel_pkg::KIND_CHASE:  site_q <= c_entry[SW-1:0];
							cel_pkg::KIND_GROWTH: site_q <= g_entry[SW-1:0];
							default:              site_q <= r_entry;
						endcase
						state_q <= S_PAINT;
					end
				end
				// recolor the site, then fix the red list for chase and growth events
				S_PAINT: begin
					r_key_q <= site_q;
					n_q     <= '0;
					case (kind_q)
						cel_pkg::KIND_CHASE: begin
							r_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_DROP_MATCH};
							state_q <= S_RED_WAIT;
						end
						cel_pkg::KIND_GROWTH: begin
							r_ctl_q <= '{go: 1'b1, clr: 1'b0, op: cel_pkg::LOP_PUSH};
							state_q <= S_RED_WAIT;
						end
						default: state_q <= S_NB_RD;
					endcase
				end
				S_RED_WAIT: begin
					if (r_done) begin
						if (kind_q == cel_pkg::KIND_GROWTH &&
						    LW'(sc) + LW'(1) == side_q) begin
							escaped_q <= 1'b1;
							stat_q    <= cel_pkg::STAT_ESCAPED;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_NB_RD;
						end
					end
				end
				// neighbour walk: up, down, left, right
				S_NB_RD: begin
					if (nb_ok) begin
						state_q <= S_NB_ACT;
					end else if (n_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						n_q <= n_q + 2'd1;
					end
				end
				S_NB_ACT: begin
					wait_g_q <= nb_to_g;
					if (nb_go) begin
						if (nb_to_g) begin
							g_ctl_q <= '{go: 1'b1, clr: 1'b0, op: nb_op};
							g_key_q <= nb_key;
						end else begin
							c_ctl_q <= '{go: 1'b1, clr: 1'b0, op: nb_op};
							c_key_q <= nb_key;
						end
						state_q <= S_NB_WAIT;
					end else if (n_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						n_q     <= n_q + 2'd1;
						state_q <= S_NB_RD;
					end
				end
				S_NB_WAIT: begin
					if ((wait_g_q && g_done) || (!wait_g_q && c_done)) begin
						if (n_q == 2'd3) begin
							state_q <= S_FIN;
						end else begin
							n_q     <= n_q + 2'd1;
							state_q <= S_NB_RD;
						end
					end
				end
				// hand the result to the output register
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q           <= 1'b1;
						out_data_q.status     <= stat_q;
						out_data_q.event_kind <= kind_q;
						out_data_q.site_row   <= 6'(sr);
						out_data_q.site_col   <= 6'(sc);
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q != S_IDLE)
		else $error("accepted item left no work");
	a_escape_latched: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && stat_q == cel_pkg::STAT_ESCAPED |-> escaped_q)
		else $error("escape reported without latch");
	a_event_has_red: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WGT1 |-> rcnt != '0)
		else $error("event started with no red site");
	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rcnt) <= RED_DEPTH)
		else $error("red count beyond depth");
`endif
endmodule
`default_nettype wire

// File: src/cel_list.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cel_list
// Unordered list in a synchronous memory: append, remove at an index and
// remove the first matching entry, each removal by swap with the last entry.
// ---------------------------------------------------------------------------
module cel_list #(
	parameter int DEPTH = 16,
	parameter int W     = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cel_pkg::lst_ctl_t            ctl,
	input  wire logic [$clog2(DEPTH)-1:0]     idx,
	input  wire logic [W-1:0]                 key,
	output logic                              done,
	output logic [W-1:0]                      entry,
	output logic [$clog2(DEPTH+1)-1:0]        count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	typedef enum logic [1:0] {S_IDLE, S_AT_LAST, S_SCAN, S_MOVE} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  k_q;
	logic [AW-1:0]  kp_q;
	logic [AW-1:0]  pos_q;
	logic           pend_q;
	logic           done_q;
	logic [W-1:0]   key_q;
	logic [W-1:0]   entry_q;
	logic [W-1:0]   mem [DEPTH];
	logic [W-1:0]   rdata_q;
	logic [AW-1:0]  raddr;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [W-1:0]   wdata;
	logic [CW-1:0]  cnt_dec;
	logic           hit;

	assign cnt_dec = cnt_q - CW'(1);
	assign hit     = pend_q && (rdata_q == key_q);
	assign done    = done_q;
	assign entry   = entry_q;
	assign count   = cnt_q;

	// address and write selection
	always_comb begin
		raddr = idx;
		we    = 1'b0;
		waddr = pos_q;
		wdata = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.go && !ctl.clr && ctl.op == cel_pkg::LOP_PUSH &&
				    cnt_q < CW'(DEPTH)) begin
					we    = 1'b1;
					waddr = cnt_q[AW-1:0];
					wdata = key;
				end
			end
			S_AT_LAST: raddr = cnt_dec[AW-1:0];
			S_SCAN: begin
				if (hit) begin
					raddr = cnt_dec[AW-1:0];
				end else begin
					raddr = k_q[AW-1:0];
				end
			end
			S_MOVE: we = 1'b1;
			default: ;
		endcase
	end

	// list memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			kp_q    <= '0;
			pos_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			key_q   <= '0;
			entry_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (ctl.clr) begin
						cnt_q <= '0;
					end else if (ctl.go) begin
						unique case (ctl.op)
							cel_pkg::LOP_PUSH: begin
								if (cnt_q < CW'(DEPTH)) begin
									cnt_q <= cnt_q + CW'(1);
								end
								done_q <= 1'b1;
							end
							cel_pkg::LOP_DROP_AT: begin
								pos_q   <= idx;
								state_q <= S_AT_LAST;
							end
							cel_pkg::LOP_DROP_MATCH: begin
								key_q   <= key;
								k_q     <= '0;
								pend_q  <= 1'b0;
								state_q <= S_SCAN;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				// latch the removed entry, last entry read in flight
				S_AT_LAST: begin
					entry_q <= rdata_q;
					state_q <= S_MOVE;
				end
				// one read issued and one compare a cycle
				S_SCAN: begin
					if (hit) begin
						pos_q   <= kp_q;
						state_q <= S_MOVE;
					end else if (k_q < cnt_q) begin
						kp_q   <= k_q[AW-1:0];
						k_q    <= k_q + CW'(1);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				// last entry fills the hole
				S_MOVE: begin
					cnt_q   <= cnt_dec;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= DEPTH)
		else $error("list count beyond depth");
	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |-> cnt_q != '0)
		else $error("removal from empty list");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("done outside idle");
`endif
endmodule
`default_nettype wire

// File: src/cel_mod.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cel_mod
// Bit-serial restoring remainder of the index draw by a list count.
// ---------------------------------------------------------------------------
module cel_mod #(
	parameter int DW = 14
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [cel_pkg::DRAW_W-1:0] num,
	input  wire logic [DW-1:0]              den,
	output logic                            done,
	output logic [DW-1:0]                   rem
);
	localparam int NB = cel_pkg::DRAW_W;
	localparam int BW = $clog2(NB);

	logic          busy_q;
	logic          done_q;
	logic [BW-1:0] bit_q;
	logic [NB-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q, num_q[NB-1]};
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign rem   = rem_q;

	// shift one dividend bit in a cycle, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= diff[DW-1:0];
				end else begin
					rem_q <= trial[DW-1:0];
				end
				num_q <= num_q << 1;
				bit_q <= bit_q + BW'(1);
				if (bit_q == BW'(NB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> den != '0)
		else $error("remainder by zero");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done while busy");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("partial remainder not reduced");
`endif
endmodule
`default_nettype wire

// File: tb/cel_lattice_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cel_lattice_checker
// Watches the item and result channels of the lattice event core, keeps its
// own copy of the lattice, bond lists and red-site list, predicts each result
// and compares it field by field with what the core returns.
// ---------------------------------------------------------------------------
module cel_lattice_checker
	import cel_pkg::*;
#(
	parameter int MAX_SIDE   = 64,
	parameter int BOND_DEPTH = 8192,
	parameter int RED_DEPTH  = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	input  wire logic                  item_ready,
	input  wire in_item_t              item_data,
	input  wire logic                  result_valid,
	input  wire logic                  result_ready,
	input  wire out_item_t             result_data,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_data,
	output int                         fail_count,
	output int                         pending_count,
	output int                         result_count
);

	typedef struct {
		int r1, c1, r2, c2;
	} link_t;

	color_t     lattice [MAX_SIDE*MAX_SIDE];
	link_t      chase_list [BOND_DEPTH];
	link_t      growth_list [BOND_DEPTH];
	int         red_row [RED_DEPTH];
	int         red_col [RED_DEPTH];
	int         n_chase, n_growth, n_red;
	int         side_reg, growth_reg, conv_reg, live_side;
	bit         escaped;
	out_item_t  expected_q [$];

	assign pending_count = expected_q.size();

	function automatic int clamp_side(int s);
		if (s < 2) return 2;
		if (s > MAX_SIDE) return MAX_SIDE;
		return s;
	endfunction

	function automatic color_t color_of(int r, int c);
		int k;
		k = r * MAX_SIDE + c;
		return (k < MAX_SIDE*MAX_SIDE) ? lattice[k] : COL_WHITE;
	endfunction

	function automatic void paint(int r, int c, color_t v);
		int k;
		k = r * MAX_SIDE + c;
		if (k < MAX_SIDE*MAX_SIDE) lattice[k] = v;
	endfunction

	function automatic void link_push(bit chase, int r1, int c1, int r2, int c2);
		link_t b;
		b.r1 = r1; b.c1 = c1; b.r2 = r2; b.c2 = c2;
		if (chase) begin
			if (n_chase < BOND_DEPTH) begin
				chase_list[n_chase] = b;
				n_chase++;
			end
		end else if (n_growth < BOND_DEPTH) begin
			growth_list[n_growth] = b;
			n_growth++;
		end
	endfunction

	function automatic void link_remove_at(bit chase, int idx);
		if (chase) begin
			if (idx < n_chase) begin
				chase_list[idx] = chase_list[n_chase-1];
				n_chase--;
			end
		end else if (idx < n_growth) begin
			growth_list[idx] = growth_list[n_growth-1];
			n_growth--;
		end
	endfunction

	function automatic void link_remove(bit chase, int r1, int c1, int r2, int c2);
		link_t b;
		int n;
		n = chase ? n_chase : n_growth;
		for (int k = 0; k < n; k++) begin
			b = chase ? chase_list[k] : growth_list[k];
			if (b.r1 == r1 && b.c1 == c1 && b.r2 == r2 && b.c2 == c2) begin
				link_remove_at(chase, k);
				return;
			end
		end
	endfunction

	function automatic void red_add(int r, int c);
		if (n_red < RED_DEPTH) begin
			red_row[n_red] = r;
			red_col[n_red] = c;
			n_red++;
		end
	endfunction

	function automatic void red_remove_at(int idx);
		if (idx < n_red) begin
			red_row[idx] = red_row[n_red-1];
			red_col[idx] = red_col[n_red-1];
			n_red--;
		end
	endfunction

	function automatic void red_remove(int r, int c);
		for (int k = 0; k < n_red; k++) begin
			if (red_row[k] == r && red_col[k] == c) begin
				red_remove_at(k);
				return;
			end
		end
	endfunction

	// refresh the bonds around a site that just took a new color
	function automatic void update_neighbors(int r, int c, color_t now_col);
		int nr[4], nc[4];
		bit ok[4];
		color_t v;
		nr[0] = (r + live_side - 1) % live_side; nc[0] = c; ok[0] = 1;
		nr[1] = (r + 1) % live_side; nc[1] = c; ok[1] = 1;
		nr[2] = r; nc[2] = c - 1; ok[2] = (c > 0);
		nr[3] = r; nc[3] = c + 1; ok[3] = (c + 1 < live_side);
		for (int n = 0; n < 4; n++) begin
			if (ok[n]) begin
				v = color_of(nr[n], nc[n]);
				if (now_col == COL_BLUE) begin
					if (v == COL_RED) link_push(1, r, c, nr[n], nc[n]);
					else if (v == COL_BLUE) link_remove(1, nr[n], nc[n], r, c);
					else if (v == COL_WHITE) link_remove(0, r, c, nr[n], nc[n]);
				end else begin
					if (v == COL_RED) link_remove(0, nr[n], nc[n], r, c);
					else if (v == COL_BLUE) link_push(1, nr[n], nc[n], r, c);
					else if (v == COL_WHITE) link_push(0, r, c, nr[n], nc[n]);
				end
			end
		end
	endfunction

	function automatic out_item_t predict_event(in_item_t it);
		out_item_t o;
		longint unsigned wb, wg, wr, lhs, u;
		int r, c, idx;
		link_t b;
		o.status = STAT_RUNNING; o.event_kind = KIND_NONE;
		o.site_row = '0; o.site_col = '0;
		r = 0; c = 0;
		if (it.cmd == CMD_START) begin
			live_side = clamp_side(side_reg);
			foreach (lattice[k]) lattice[k] = COL_WHITE;
			n_chase = 0; n_growth = 0; n_red = 0; escaped = 0;
			for (int i = 0; i < live_side; i++) begin
				paint(i, 0, COL_BLUE);
				paint(i, 1, COL_RED);
				link_push(1, i, 0, i, 1);
				if (live_side > 2) link_push(0, i, 1, i, 2);
				red_add(i, 1);
			end
			return o;
		end
		if (escaped) begin
			o.status = STAT_ESCAPED;
			return o;
		end
		if (n_red == 0) begin
			o.status = STAT_EXTINCT;
			return o;
		end
		u = it.uniform_draw;
		wb = longint'(n_chase) << FRAC_W;
		wg = longint'(growth_reg) * n_growth;
		wr = longint'(conv_reg) * n_red;
		lhs = u * (wb + wg + wr);
		if (lhs < (wb << 16)) begin
			idx = it.index_draw % n_chase;
			b = chase_list[idx];
			link_remove_at(1, idx);
			r = b.r2; c = b.c2;
			paint(r, c, COL_BLUE);
			red_remove(r, c);
			update_neighbors(r, c, COL_BLUE);
			o.event_kind = KIND_CHASE;
		end else if (lhs < ((wb + wg) << 16)) begin
			idx = it.index_draw % n_growth;
			b = growth_list[idx];
			link_remove_at(0, idx);
			r = b.r2; c = b.c2;
			paint(r, c, COL_RED);
			red_add(r, c);
			o.event_kind = KIND_GROWTH;
			if (c + 1 == live_side) begin
				escaped = 1;
				o.status = STAT_ESCAPED;
			end else begin
				update_neighbors(r, c, COL_RED);
			end
		end else begin
			idx = it.index_draw % n_red;
			r = red_row[idx]; c = red_col[idx];
			red_remove_at(idx);
			paint(r, c, COL_BLUE);
			update_neighbors(r, c, COL_BLUE);
			o.event_kind = KIND_CONV;
		end
		o.site_row = r[5:0];
		o.site_col = c[5:0];
		return o;
	endfunction

	// track register writes, predict on each item transfer, check each result
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (lattice[k]) lattice[k] = COL_WHITE;
			n_chase = 0; n_growth = 0; n_red = 0; escaped = 0;
			side_reg = SIDE_RST; growth_reg = GROWTH_RST; conv_reg = CONV_RST;
			live_side = clamp_side(side_reg);
			expected_q.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SIDE:   side_reg = cfg_data[SIDE_W-1:0];
					REG_GROWTH: growth_reg = cfg_data;
					REG_CONV:   conv_reg = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				result_count++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result_data);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (want.status !== result_data.status
							|| want.event_kind !== result_data.event_kind
							|| want.site_row !== result_data.site_row
							|| want.site_col !== result_data.site_col) begin
						$display("%0t: mismatch expected %p actual %p", $time, want,
							result_data);
						fail_count++;
					end
				end
			end
			if (item_valid && item_ready)
				expected_q.push_back(predict_event(item_data));
		end
	end

endmodule
`default_nettype wire

// File: tb/chase_escape_lattice_event_step_core_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chase_escape_lattice_event_step_core_test
// Drives start and event commands into the lattice event core under random
// gaps and stalls across several register settings; the checker predicts
// and compares every result.
// ---------------------------------------------------------------------------
module chase_escape_lattice_event_step_core_test;
	import cel_pkg::*;

	localparam int WATCHDOG = 400000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_addr;
	logic [CFG_W-1:0]  cfg_data;
	logic              hold_result;
	int                fail_count, pending_count, result_count, idle_cycles;
	bit                timed_out;

	cel_stream_if #(.payload_t(in_item_t))  item_ch ();
	cel_stream_if #(.payload_t(out_item_t)) result_ch ();

	chase_escape_lattice_event_step_core DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(result_ch.source),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	cel_lattice_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_ch.valid), .item_ready(item_ch.ready), .item_data(item_ch.data),
		.result_valid(result_ch.valid), .result_ready(result_ch.ready),
		.result_data(result_ch.data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// random stalls on the result side, with a long hold-off on request
	initial begin
		int w;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_result) begin
				result_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_result = 0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (w > 0) begin
				result_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	// count cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_item(logic cmd, logic [UNI_W-1:0] u, logic [DRAW_W-1:0] d,
			bit gaps);
		int w;
		w = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
		if (w > 0) begin
			item_ch.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= '{cmd: cmd, uniform_draw: u, index_draw: d};
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one realization: start, then a run of events with random content
	task automatic run_realization(int n_events);
		send_item(CMD_START, UNI_W'($urandom), DRAW_W'($urandom), 1);
		for (int i = 0; i < n_events; i++)
			send_item(CMD_EVENT, UNI_W'($urandom), DRAW_W'($urandom), 1);
	endtask

	initial begin
		int sent, n;
		logic [15:0] g, cv;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_addr = REG_SIDE; cfg_data = '0;
		item_ch.valid = 1'b0; item_ch.data = '0;
		hold_result = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: events before any start, then the field extremes
		send_item(CMD_EVENT, 16'h0000, 31'h0, 0);
		send_item(CMD_EVENT, 16'hFFFF, 31'h7FFFFFFF, 0);
		drain();
		write_reg(REG_SIDE, CFG_W'(3));
		send_item(CMD_START, 16'hFFFF, 31'h7FFFFFFF, 0);
		send_item(CMD_EVENT, 16'h0000, 31'h0, 0);
		send_item(CMD_EVENT, 16'hFFFF, 31'h7FFFFFFF, 0);
		send_item(CMD_EVENT, 16'h8000, 31'h55555555, 0);
		send_item(CMD_EVENT, 16'h7FFF, 31'h2AAAAAAA, 0);
		// long hold-off on the result side while items keep coming
		hold_result = 1;
		for (int i = 0; i < 8; i++)
			send_item(CMD_EVENT, UNI_W'($urandom), DRAW_W'($urandom), 0);
		drain();
		// side of two, zero rates: chase only, then extinction
		write_reg(REG_SIDE, CFG_W'(0));
		write_reg(REG_GROWTH, CFG_W'(0));
		write_reg(REG_CONV, CFG_W'(0));
		send_item(CMD_START, '0, '0, 0);
		for (int i = 0; i < 4; i++) send_item(CMD_EVENT, 16'hFFFF, DRAW_W'($urandom), 0);
		drain();
		// growth only toward escape, with latched status after
		write_reg(REG_SIDE, CFG_W'(4));
		write_reg(REG_GROWTH, 16'hFFFF);
		send_item(CMD_START, '0, '0, 0);
		for (int i = 0; i < 6; i++) send_item(CMD_EVENT, 16'hFFFF, DRAW_W'($urandom), 0);
		drain();

		// random phases over register settings
		sent = 27;
		while (sent < 700) begin
			case ($urandom_range(0, 4))
				0: write_reg(REG_SIDE, CFG_W'(127));
				1: write_reg(REG_SIDE, CFG_W'(64));
				default: write_reg(REG_SIDE, CFG_W'($urandom_range(1, 8)));
			endcase
			g = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 12000));
			cv = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6000));
			write_reg(REG_GROWTH, g);
			write_reg(REG_CONV, cv);
			for (int k = 0; k < 4; k++) begin
				n = $urandom_range(5, 30);
				run_realization(n);
				sent += n + 1;
			end
			if ($urandom_range(0, 3) == 0) begin
				send_item(CMD_EVENT, UNI_W'($urandom), DRAW_W'($urandom), 1);
				sent++;
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
